/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ERPD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("erpd check failed");

// Next-cycle implication, disabled while reset is high.
`define ERPD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("erpd check failed");

`endif

/* rtl/core/erpd_pkg.sv */
package erpd_pkg;

  localparam int SEQ_W  = 64;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 8;

  typedef struct packed {
    logic [WORD_W-1:0] kind;
    logic [WORD_W-1:0] slot;
    logic [WORD_W-1:0] extra;
  } entry_t;

  typedef struct packed {
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

endpackage

/* rtl/core/erpd_if.sv */
interface erpd_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] event_kind;
  logic [31:0] event_slot;
  logic [31:0] event_extra;
  logic [63:0] reader_tail;
  logic [7:0]  max_count;

  modport source (output valid, req_type, event_kind, event_slot, event_extra,
                  reader_tail, max_count, input ready);
  modport sink (input valid, req_type, event_kind, event_slot, event_extra,
                reader_tail, max_count, output ready);
endinterface

interface erpd_rsp_if;
  logic        valid;
  logic        ready;
  logic        has_entry;
  logic [63:0] entry_seq;
  logic [31:0] entry_kind;
  logic [31:0] entry_slot;
  logic [31:0] entry_extra;
  logic [63:0] new_tail;
  logic        overflow;
  logic        is_last;

  modport source (output valid, has_entry, entry_seq, entry_kind, entry_slot,
                  entry_extra, new_tail, overflow, is_last, input ready);
  modport sink (input valid, has_entry, entry_seq, entry_kind, entry_slot,
                entry_extra, new_tail, overflow, is_last, output ready);
endinterface

/* rtl/core/erpd_mem.sv */
module erpd_mem #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  erpd_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output erpd_pkg::entry_t rd_data
);
  import erpd_pkg::*;

  entry_t ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ram[rd_addr];
  end

endmodule

/* rtl/core/erpd_alu.sv */
module erpd_alu (
  input  erpd_pkg::alu_req_t op,
  output erpd_pkg::alu_rsp_t res
);
  import erpd_pkg::*;

  logic [SEQ_W-1:0] b_opnd;

  // Subtraction is a plus the inverted b plus one; carry out high means no borrow.
  assign b_opnd = op.sub ? ~op.b : op.b;
  assign {res.carry, res.sum} = {1'b0, op.a} + {1'b0, b_opnd} + (SEQ_W + 1)'(op.sub);

endmodule

/* rtl/core/event_ring_publish_drain_top.sv */
// Channel | Dir | Words
// req     | in  | publish (req_type 0) or drain (req_type 1) request
// rsp     | out | one word per publish, one or more words per drain
//
// A publish passes through the accepting cycle and a write state (ST_PUB) that writes
// the ring and loads its word into the output register.
// A drain passes through setup (accepting cycle, ST_CMP, ST_SNAP on overflow, ST_PREP),
// then ST_RD (memory read) and ST_EM (emit on the shared 64-bit adder) for each entry.
// The block takes no new request until the last word of the current one is loaded.
// A stall on rsp holds only word-loading states. Reset clears the head, not the ring.
module event_ring_publish_drain_top #(
  parameter int RING_DEPTH = 64
) (
  input logic       clk,
  input logic       rst,
  erpd_req_if.sink  req,
  erpd_rsp_if.source rsp
);
  import erpd_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] HALF    = PW'(RING_DEPTH / 2);
  localparam logic [PW-1:0] QUARTER = PW'(RING_DEPTH / 4);
  localparam logic [PW-1:0] LAST_POS = PW'(RING_DEPTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PUB  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_SNAP = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_NONE = 3'd5;
  localparam logic [2:0] ST_RD   = 3'd6;
  localparam logic [2:0] ST_EM   = 3'd7;

  logic [2:0]       state;
  logic [SEQ_W-1:0] head;
  logic [PW-1:0]    head_pos;
  logic [SEQ_W-1:0] tail;
  logic [CNT_W-1:0] max_cnt;
  logic [PW-1:0]    lag;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    cnt;
  logic             ovf;
  entry_t           pub_entry;

  logic             out_vld;
  logic             o_has;
  logic [SEQ_W-1:0] o_seq;
  entry_t           o_entry;
  logic [SEQ_W-1:0] o_tail;
  logic             o_ovf;
  logic             o_last;

  alu_req_t         alu_op;
  alu_rsp_t         alu_res;
  entry_t           rd_data;
  logic             out_free;
  logic             out_load;
  logic             mem_wr;
  logic [PW:0]      pos_wide;
  logic [PW-1:0]    start_pos;
  logic [PW-1:0]    first_cnt;
  logic             lag_big;

  assign out_free = !out_vld || rsp.ready;
  assign mem_wr   = (state == ST_PUB) && out_free;
  assign req.ready = (state == ST_IDLE);

  assign rsp.valid       = out_vld;
  assign rsp.has_entry   = o_has;
  assign rsp.entry_seq   = o_seq;
  assign rsp.entry_kind  = o_entry.kind;
  assign rsp.entry_slot  = o_entry.slot;
  assign rsp.entry_extra = o_entry.extra;
  assign rsp.new_tail    = o_tail;
  assign rsp.overflow    = o_ovf;
  assign rsp.is_last     = o_last;

  erpd_mem #(.DEPTH(RING_DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (head_pos),
    .wr_data (pub_entry),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  erpd_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  always_comb begin
    alu_op.a   = tail;
    alu_op.b   = SEQ_W'(1);
    alu_op.sub = 1'b0;
    unique case (state)
      ST_PUB: begin
        alu_op.a = head;
      end
      ST_CMP: begin
        alu_op.a   = head;
        alu_op.b   = tail;
        alu_op.sub = 1'b1;
      end
      ST_SNAP: begin
        alu_op.a   = head;
        alu_op.b   = SEQ_W'(QUARTER);
        alu_op.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The reader lag is at most half the ring here, so the tail position is
  // the head position stepped back by the lag, modulo the ring depth.
  always_comb begin
    if (head_pos >= lag) begin
      pos_wide = {1'b0, head_pos} - {1'b0, lag};
    end else begin
      pos_wide = (PW + 1)'(RING_DEPTH) + {1'b0, head_pos} - {1'b0, lag};
    end
    start_pos = pos_wide[PW-1:0];
    if (CNT_W'(lag) <= max_cnt) begin
      first_cnt = lag;
    end else begin
      first_cnt = max_cnt[PW-1:0];
    end
  end

  assign lag_big = (|alu_res.sum[SEQ_W-1:PW]) || (alu_res.sum[PW-1:0] > HALF);

  // The output register is loaded in every state that emits a word.
  always_comb begin
    unique case (state)
      ST_PUB, ST_NONE, ST_EM: out_load = out_free;
      ST_CMP:                 out_load = out_free && !alu_res.carry;
      default:                out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      head_pos <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            tail      <= req.reader_tail;
            max_cnt   <= req.max_count;
            ovf       <= 1'b0;
            pub_entry <= '{kind: req.event_kind, slot: req.event_slot,
                           extra: req.event_extra};
            state     <= req.req_type ? ST_CMP : ST_PUB;
          end
        end
        ST_PUB: begin
          if (out_free) begin
            o_has    <= 1'b0;
            o_seq    <= head;
            o_entry  <= '0;
            o_tail   <= '0;
            o_ovf    <= 1'b0;
            o_last   <= 1'b1;
            head     <= alu_res.sum;
            head_pos <= (head_pos == LAST_POS) ? '0 : head_pos + 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_CMP: begin
          if (!alu_res.carry) begin
            // Tail ahead of head: clamp and give no entries.
            if (out_free) begin
              o_has   <= 1'b0;
              o_seq   <= '0;
              o_entry <= '0;
              o_tail  <= head;
              o_ovf   <= 1'b0;
              o_last  <= 1'b1;
              state   <= ST_IDLE;
            end
          end else if (lag_big) begin
            ovf   <= 1'b1;
            state <= ST_SNAP;
          end else begin
            lag   <= alu_res.sum[PW-1:0];
            state <= ST_PREP;
          end
        end
        ST_SNAP: begin
          tail  <= alu_res.sum;
          lag   <= QUARTER;
          state <= ST_PREP;
        end
        ST_PREP: begin
          pos   <= start_pos;
          cnt   <= first_cnt;
          state <= (first_cnt == '0) ? ST_NONE : ST_RD;
        end
        ST_NONE: begin
          if (out_free) begin
            o_has   <= 1'b0;
            o_seq   <= '0;
            o_entry <= '0;
            o_tail  <= tail;
            o_ovf   <= ovf;
            o_last  <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_RD: begin
          state <= ST_EM;
        end
        ST_EM: begin
          if (out_free) begin
            // An entry within half a ring of the head was last written with
            // the sequence equal to its cursor, so the cursor is its tag.
            o_has   <= 1'b1;
            o_seq   <= tail;
            o_entry <= rd_data;
            o_tail  <= alu_res.sum;
            o_ovf   <= ovf;
            o_last  <= (cnt == PW'(1));
            tail    <= alu_res.sum;
            pos     <= (pos == LAST_POS) ? '0 : pos + 1'b1;
            cnt     <= cnt - 1'b1;
            state   <= (cnt == PW'(1)) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/erpd_chk.sv */
`include "assert_macros.svh"

module erpd_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic                     has_entry,
  input logic [erpd_pkg::SEQ_W-1:0] entry_seq,
  input logic [erpd_pkg::SEQ_W-1:0] new_tail,
  input logic                     is_last
);
  import erpd_pkg::*;

  // Acceptance always moves the block out of idle, so ready drops after acceptance.
  `ERPD_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // A word without an entry always closes its request.
  `ERPD_ASSERT_IMP(a_empty_is_last, clk, rst, rsp_valid && !has_entry, is_last)

  // An entry moves the reader cursor just past itself.
  `ERPD_ASSERT_IMP(a_tail_follows, clk, rst, rsp_valid && has_entry,
                   new_tail == entry_seq + SEQ_W'(1))

  `ERPD_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(entry_seq) && $stable(new_tail) && $stable(is_last))

endmodule

bind event_ring_publish_drain_top erpd_chk u_erpd_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .has_entry (rsp.has_entry),
  .entry_seq (rsp.entry_seq),
  .new_tail  (rsp.new_tail),
  .is_last   (rsp.is_last)
);
